FILE: design/sit_pkg.sv
`timescale 1ns / 1ps

package sit_pkg;

  localparam int TIME_W            = 16;
  localparam int TIME_LIMIT        = 65535;
  localparam int DEF_NUM_LOCATIONS = 16;
  localparam int DEF_MAX_INTERVALS = 16;
  localparam int LOC_FIELD_W       = 4;

  localparam logic [TIME_W-1:0] HORIZON_RST = 16'd65534;
  localparam logic [TIME_W-1:0] TIME_LAST   = TIME_W'(TIME_LIMIT - 1);

  typedef enum logic [1:0] {
    FN_INIT  = 2'd0,
    FN_BLOCK = 2'd1,
    FN_MARK  = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]             func;
    logic [LOC_FIELD_W-1:0] location;
    logic [TIME_W-1:0]      t_min;
    logic [TIME_W-1:0]      t_max;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] interval_low;
    logic [TIME_W-1:0] interval_high;
    logic              soft_hit;
    logic [1:0]        status;
  } out_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] low;
    logic [TIME_W-1:0] high;
    logic              mark;
  } span_t;

  typedef struct packed {
    logic    load;
    logic    init;
    logic    next;
    logic    push;
    logic    clr_idx;
    logic    commit;
    logic    copy_wr;
    logic    q_hit;
    logic    set_st;
    status_t st;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       bad_loc;
    logic       empty;
    logic       bad_range;
    logic       q_beyond;
    logic       q_hit;
    logic       q_stop;
    logic       idx_last;
    logic       sub_last;
    logic       over;
    logic       none;
    logic       copy_last;
  } dp_stat_t;

  function automatic logic [TIME_W-1:0] list_end(input logic [TIME_W-1:0] h);
    logic [TIME_W-1:0] m;
    m = (h < TIME_LAST) ? h : TIME_LAST;
    return m + TIME_W'(1);
  endfunction

  localparam span_t RST_SPAN = '{low: '0, high: list_end(HORIZON_RST), mark: 1'b0};

endpackage

FILE: design/sit_ctrl.sv
`timescale 1ns / 1ps

module sit_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_strobe,
  input  sit_pkg::dp_stat_t stat,
  output sit_pkg::ctl_cmd_t cmd
);
  import sit_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_QUERY  = 7'b0000100,
    S_PUSH   = 7'b0001000,
    S_FLUSH  = 7'b0010000,
    S_COPY   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st    = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.bad_loc) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_EMPTY;
          state_nxt  = S_DONE;
        end else if (stat.func == FN_INIT) begin
          cmd.init  = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.empty) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_EMPTY;
          state_nxt  = S_DONE;
        end else if (stat.func == FN_QUERY) begin
          state_nxt = stat.q_beyond ? S_DONE : S_QUERY;
        end else if (stat.bad_range) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_EMPTY;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_QUERY: begin
        if (stat.q_hit) begin
          cmd.q_hit = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.q_stop || stat.idx_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next = 1'b1;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (stat.sub_last) begin
          if (stat.idx_last) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.next = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (stat.over) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_OVERFLOW;
          state_nxt  = S_DONE;
        end else begin
          cmd.commit  = 1'b1;
          cmd.clr_idx = 1'b1;
          state_nxt   = stat.none ? S_DONE : S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_wr = 1'b1;
        if (stat.copy_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next = 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

endmodule

FILE: design/sit_dpath.sv
`timescale 1ns / 1ps

module sit_dpath #(
  parameter int NUM_LISTS     = 16,
  parameter int MAX_INTERVALS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sit_pkg::in_word_t  in_word,
  input  logic               cfg_wr,
  input  logic [15:0]        cfg_data,
  input  sit_pkg::ctl_cmd_t  cmd,
  output sit_pkg::dp_stat_t  stat,
  output sit_pkg::out_word_t out_word
);
  import sit_pkg::*;

  localparam int IDX_W  = $clog2(MAX_INTERVALS);
  localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int LOC_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int DEPTH  = NUM_LISTS * MAX_INTERVALS;
  localparam int ADDR_W = $clog2(DEPTH);

  in_word_t          op_r;
  logic [TIME_W-1:0] horizon_r;
  logic [CNT_W-1:0]  count_r [NUM_LISTS];
  logic              fresh_r [NUM_LISTS];
  span_t             store   [DEPTH];
  span_t             rd_data_r;
  span_t             scratch [MAX_INTERVALS];
  span_t             sc_data_r;
  span_t             hold_r, hold_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              over_r, over_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [1:0]        sub_r, sub_nxt;
  out_word_t         res_r, res_nxt;

  logic [LOC_W-1:0]  loc_rd, cur;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              st_we;
  span_t             st_wdata;
  logic              sc_we;
  logic [IDX_W-1:0]  sc_waddr;
  span_t             ent, cand;
  logic              cand_en, pass, is_mark;
  logic [TIME_W-1:0] a, b, end_t;
  logic [CNT_W-1:0]  cnt_cur, idx_ext;

  assign a       = op_r.t_min;
  assign b       = op_r.t_max;
  assign end_t   = list_end(horizon_r);
  assign is_mark = (op_r.func == FN_MARK);
  assign cur     = op_r.location[LOC_W-1:0];
  assign loc_rd  = cmd.load ? in_word.location[LOC_W-1:0] : cur;
  assign cnt_cur = count_r[cur];
  assign idx_ext = CNT_W'(idx_r);
  assign ent     = fresh_r[cur] ? RST_SPAN : rd_data_r;

  always_comb begin
    if (cmd.load || cmd.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd.next) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
    if (cmd.load || cmd.next) begin
      sub_nxt = '0;
    end else if (cmd.push) begin
      sub_nxt = sub_r + 2'd1;
    end else begin
      sub_nxt = sub_r;
    end
  end

  assign rd_addr = ADDR_W'(int'(loc_rd) * MAX_INTERVALS + int'(idx_nxt));
  assign wr_addr = ADDR_W'(int'(cur) * MAX_INTERVALS + (cmd.init ? 0 : int'(idx_r)));
  assign st_we   = cmd.init || cmd.copy_wr;

  always_comb begin
    if (cmd.init) begin
      st_wdata = '{low: '0, high: end_t, mark: 1'b0};
    end else if (idx_ext + CNT_W'(1) == n_r) begin
      st_wdata = hold_r;
    end else begin
      st_wdata = sc_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[wr_addr] <= st_wdata;
    end
    rd_data_r <= store[rd_addr];
  end

  always_comb begin
    pass    = (is_mark && ent.mark) || (ent.high <= a) || (ent.low >= b);
    cand    = ent;
    cand_en = 1'b0;
    case (sub_r)
      2'd0: begin
        if (pass) begin
          cand_en = 1'b1;
        end else begin
          cand    = '{low: ent.low, high: a, mark: ent.mark && !is_mark};
          cand_en = (ent.low < a);
        end
      end
      2'd1: begin
        if (is_mark) begin
          cand    = '{low: (ent.low > a) ? ent.low : a,
                      high: (ent.high < b) ? ent.high : b, mark: 1'b1};
          cand_en = !pass;
        end else begin
          cand    = '{low: b, high: ent.high, mark: ent.mark};
          cand_en = !pass && (ent.high > b);
        end
      end
      2'd2: begin
        cand    = '{low: b, high: ent.high, mark: 1'b0};
        cand_en = is_mark && !pass && (ent.high > b);
      end
      default: begin
        cand_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    hold_nxt = hold_r;
    n_nxt    = n_r;
    over_nxt = over_r;
    sc_we    = 1'b0;
    sc_waddr = IDX_W'(n_r - CNT_W'(1));
    if (cmd.load) begin
      n_nxt    = '0;
      over_nxt = 1'b0;
    end else if (cmd.push && cand_en) begin
      if (is_mark && cand.mark && n_r != '0 && hold_r.mark && hold_r.high == cand.low) begin
        if (cand.high > hold_r.high) begin
          hold_nxt.high = cand.high;
        end
      end else if (n_r >= CNT_W'(MAX_INTERVALS)) begin
        over_nxt = 1'b1;
      end else begin
        sc_we    = (n_r != '0);
        hold_nxt = cand;
        n_nxt    = n_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      scratch[sc_waddr] <= hold_r;
    end
    sc_data_r <= scratch[idx_nxt];
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.load) begin
      res_nxt = '0;
    end else if (cmd.set_st) begin
      res_nxt.status = cmd.st;
    end else if (cmd.q_hit) begin
      res_nxt.found         = 1'b1;
      res_nxt.interval_low  = a;
      res_nxt.interval_high = ent.high;
      res_nxt.soft_hit      = ent.mark;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_word;
    end
    hold_r <= hold_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= HORIZON_RST;
      n_r       <= '0;
      over_r    <= 1'b0;
      idx_r     <= '0;
      sub_r     <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        count_r[i] <= CNT_W'(1);
        fresh_r[i] <= 1'b1;
      end
    end else begin
      if (cfg_wr) begin
        horizon_r <= cfg_data;
      end
      n_r    <= n_nxt;
      over_r <= over_nxt;
      idx_r  <= idx_nxt;
      sub_r  <= sub_nxt;
      if (cmd.init) begin
        count_r[cur] <= CNT_W'(1);
        fresh_r[cur] <= 1'b0;
      end else if (cmd.commit) begin
        count_r[cur] <= n_r;
        fresh_r[cur] <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.func      = op_r.func;
    stat.bad_loc   = (int'(op_r.location) >= NUM_LISTS);
    stat.empty     = (cnt_cur == '0);
    stat.bad_range = (a >= b);
    stat.q_beyond  = (a >= end_t);
    stat.q_hit     = (ent.low <= a) && (a < ent.high);
    stat.q_stop    = (a < ent.low);
    stat.idx_last  = (idx_ext + CNT_W'(1) == cnt_cur);
    stat.sub_last  = (sub_r == 2'd2);
    stat.over      = over_r;
    stat.none      = (n_r == '0);
    stat.copy_last = (idx_ext + CNT_W'(1) == n_r);
  end

  assign out_word = res_r;

endmodule

FILE: design/safe_interval_table.sv
`timescale 1ns / 1ps
// Channel   Ports                               Handshake
// input     start, busy, in_word                taken when start && !busy
// result    out_strobe, out_word                one-cycle strobe, no backpressure
// config    cfg_valid, cfg_ready, cfg_data      written when cfg_valid && cfg_ready
//
// Init and rejected words go from decode straight to the result strobe; a query
// walks the stored entries in order until a hit, a later entry or the last one.
// Block and mark take three push steps per stored entry of the list, one flush step,
// then one store write per resulting entry through the single list-memory port.
// Reset is synchronous; every list comes up as one clean interval, no clearing pass.
// busy stays high until the result strobe has gone by; the receiver cannot stall.

module safe_interval_table #(
  parameter int NUM_LOCATIONS = sit_pkg::DEF_NUM_LOCATIONS,
  parameter int MAX_INTERVALS = sit_pkg::DEF_MAX_INTERVALS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sit_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output sit_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import sit_pkg::*;

  localparam int NUM_LISTS = (NUM_LOCATIONS < 16) ? NUM_LOCATIONS : 16;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sit_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .stat       (stat),
    .cmd        (cmd)
  );

  sit_dpath #(
    .NUM_LISTS     (NUM_LISTS),
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule

FILE: design/sit_checker.sv
`timescale 1ns / 1ps

module sit_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input sit_pkg::out_word_t out_word
);
  import sit_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy ##1 !busy)
    else $error("block not idle after result");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.found |-> out_word.status == ST_OK)
    else $error("found result with error status");

endmodule

bind safe_interval_table sit_checker u_sit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);

FILE: sim/interval_checker.sv
`timescale 1ns / 1ps

module interval_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  sit_pkg::in_word_t  in_word,
  input  logic               out_strobe,
  input  sit_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);
  import sit_pkg::*;

  localparam int NLOC = 16;
  localparam int NMAX = 16;

  typedef struct {
    int unsigned lo;
    int unsigned hi;
    bit          mk;
  } seg_t;

  int unsigned horizon_q;
  seg_t        lists [NLOC][NMAX];
  int unsigned counts [NLOC];
  out_word_t   expected_words [$];

  seg_t        work [NMAX];
  int unsigned work_n;
  bit          work_over;
  bit          work_merge;

  function automatic int unsigned span_end();
    int unsigned h;
    h = (horizon_q < 65534) ? horizon_q : 65534;
    return h + 1;
  endfunction

  function automatic void reset_list(int unsigned loc);
    lists[loc][0] = '{0, span_end(), 1'b0};
    counts[loc] = 1;
  endfunction

  function automatic void append_seg(int unsigned lo, int unsigned hi, bit mk);
    if (work_merge && mk && work_n > 0 && work[work_n-1].mk && work[work_n-1].hi == lo) begin
      if (hi > work[work_n-1].hi) work[work_n-1].hi = hi;
      return;
    end
    if (work_n >= NMAX) begin
      work_over = 1;
      return;
    end
    work[work_n] = '{lo, hi, mk};
    work_n++;
  endfunction

  function automatic out_word_t apply_op(in_word_t w);
    out_word_t   r;
    int unsigned loc, a, b;
    seg_t        s;
    r = '0;
    loc = w.location;
    a = w.t_min;
    b = w.t_max;
    if (w.func == FN_INIT) begin
      reset_list(loc);
    end else if (counts[loc] == 0) begin
      r.status = ST_EMPTY;
    end else if (w.func == FN_QUERY) begin
      if (a < span_end()) begin
        for (int i = 0; i < counts[loc]; i++) begin
          s = lists[loc][i];
          if (s.lo <= a && a < s.hi) begin
            r.found = 1'b1;
            r.interval_low = 16'(a);
            r.interval_high = 16'(s.hi);
            r.soft_hit = s.mk;
            break;
          end
          if (a < s.lo) break;
        end
      end
    end else if (a >= b) begin
      r.status = ST_EMPTY;
    end else begin
      work_n = 0;
      work_over = 0;
      work_merge = (w.func == FN_MARK);
      for (int i = 0; i < counts[loc]; i++) begin
        s = lists[loc][i];
        if (s.hi <= a || s.lo >= b || (w.func == FN_MARK && s.mk)) begin
          append_seg(s.lo, s.hi, s.mk);
        end else if (w.func == FN_BLOCK) begin
          if (s.lo < a) append_seg(s.lo, a, s.mk);
          if (s.hi > b) append_seg(b, s.hi, s.mk);
        end else begin
          if (s.lo < a) append_seg(s.lo, a, 0);
          append_seg(s.lo > a ? s.lo : a, s.hi < b ? s.hi : b, 1);
          if (s.hi > b) append_seg(b, s.hi, 0);
        end
      end
      if (work_over) begin
        r.status = ST_OVERFLOW;
      end else begin
        for (int i = 0; i < work_n; i++) lists[loc][i] = work[i];
        counts[loc] = work_n;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      horizon_q = 65534;
      for (int i = 0; i < NLOC; i++) reset_list(i);
      expected_words.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (out_strobe) begin
        results_seen <= results_seen + 1;
        if (expected_words.size() == 0) begin
          $error("unexpected result word");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (out_word != e) begin
            if (out_word.found != e.found)
              $error("found: expected %0d, got %0d", e.found, out_word.found);
            if (out_word.interval_low != e.interval_low)
              $error("interval_low: expected %0d, got %0d", e.interval_low,
                     out_word.interval_low);
            if (out_word.interval_high != e.interval_high)
              $error("interval_high: expected %0d, got %0d", e.interval_high,
                     out_word.interval_high);
            if (out_word.soft_hit != e.soft_hit)
              $error("soft_hit: expected %0d, got %0d", e.soft_hit, out_word.soft_hit);
            if (out_word.status != e.status)
              $error("status: expected %0d, got %0d", e.status, out_word.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) horizon_q = cfg_data;
      if (start && !busy) expected_words.push_back(apply_op(in_word));
    end
    pending <= expected_words.size();
  end
endmodule

FILE: sim/safe_interval_table_test.sv
`timescale 1ns / 1ps

module safe_interval_table_test;
  import sit_pkg::*;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_strobe;
  out_word_t out_word;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic [15:0] cfg_data = '0;
  int        fail_count, pending, results_seen;
  int        items_sent = 0;
  int        stall_cycles = 0;
  bit        quiet = 0;
  bit        timed_out = 0;

  localparam int WATCHDOG = 20000;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  safe_interval_table dut (.*);

  interval_checker chk (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("safe_interval_table_test NOT OK");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] f, logic [3:0] loc, logic [15:0] a, logic [15:0] b);
    while (!quiet && $urandom_range(99) < 30) @(posedge clk);
    start <= 1;
    in_word <= '{func: f, location: loc, t_min: a, t_max: b};
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    start <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_horizon(logic [15:0] h);
    drain();
    cfg_valid <= 1;
    cfg_data <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_time(int unsigned span);
    if ($urandom_range(19) == 0) return 16'($urandom_range(65535));
    return 16'($urandom_range(span));
  endfunction

  task automatic random_phase(int n, int unsigned span);
    logic [15:0] a, b;
    logic [3:0]  loc;
    logic [1:0]  f;
    for (int i = 0; i < n; i++) begin
      loc = 4'(($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3));
      case ($urandom_range(9))
        0:       f = FN_INIT;
        1, 2, 3: f = FN_BLOCK;
        4, 5, 6: f = FN_MARK;
        default: f = FN_QUERY;
      endcase
      a = rand_time(span);
      b = ($urandom_range(9) == 0) ? rand_time(span)
                                   : 16'(a + $urandom_range(1, span / 4 + 1));
      send_word(f, loc, a, b);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_word(FN_QUERY, 0, 0, 0);
    send_word(FN_QUERY, 0, 16'd65534, 0);
    send_word(FN_QUERY, 0, 16'hFFFF, 16'hFFFF);
    send_word(FN_BLOCK, 1, 10, 10);
    send_word(FN_MARK, 1, 20, 5);
    send_word(FN_BLOCK, 1, 10, 20);
    send_word(FN_QUERY, 1, 15, 0);
    send_word(FN_QUERY, 1, 5, 0);
    send_word(FN_MARK, 1, 0, 12);
    send_word(FN_MARK, 1, 20, 30);
    send_word(FN_QUERY, 1, 0, 0);
    send_word(FN_QUERY, 1, 25, 0);
    send_word(FN_BLOCK, 2, 0, 16'hFFFF);
    send_word(FN_QUERY, 2, 3, 0);
    send_word(FN_MARK, 2, 0, 9);
    send_word(FN_BLOCK, 2, 1, 2);
    for (int i = 0; i < 9; i++) send_word(FN_BLOCK, 15, 16'(4 * i + 1), 16'(4 * i + 2));
    send_word(FN_MARK, 15, 0, 16'hFFFF);
    send_word(FN_INIT, 15, 16'hFFFF, 16'hFFFF);
    write_horizon(16'd0);
    send_word(FN_INIT, 3, 0, 0);
    send_word(FN_QUERY, 3, 0, 0);
    send_word(FN_QUERY, 3, 1, 0);
    write_horizon(16'd65535);
    send_word(FN_INIT, 3, 0, 0);
    send_word(FN_QUERY, 3, 16'd65534, 0);
    write_horizon(16'd200);
    quiet = 1;
    random_phase(300, 220);
    quiet = 0;
    random_phase(500, 220);
    write_horizon(16'd65535);
    random_phase(400, 65535);
    write_horizon(16'($urandom_range(1, 65534)));
    random_phase(300, 1000);
    write_horizon(16'd65534);
    random_phase(300, 300);
    drain();
    $display("Sent %0d words, checked %0d results over five horizon settings.",
             items_sent, results_seen);
    if (fail_count == 0) $display("safe_interval_table_test OK");
    else $display("safe_interval_table_test NOT OK");
    $finish;
  end
endmodule

FILE: safe_interval_table.f
design/sit_pkg.sv
design/sit_ctrl.sv
design/sit_dpath.sv
design/safe_interval_table.sv
design/sit_checker.sv
sim/interval_checker.sv
sim/safe_interval_table_test.sv
